// ===== hdl/velocity_command_frame_receiver_top_macros.svh =====
// assertion macros for the command frame receiver
// used by velocity_command_frame_receiver_top, expects i_clk and i_rst_n in scope
`ifndef VELOCITY_COMMAND_FRAME_RECEIVER_TOP_MACROS_SVH
`define VELOCITY_COMMAND_FRAME_RECEIVER_TOP_MACROS_SVH

// same-cycle implication
`define VCFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/vcfr_pkg.sv =====
// shared types and constants for the command frame receiver
// no dependencies
`timescale 1ns / 1ps

package vcfr_pkg;

    localparam int unsigned FRAME_LEN = 11;
    localparam int unsigned POS_W     = 4;

    localparam logic [POS_W-1:0] POS_HEAD  = 4'd0;
    localparam logic [POS_W-1:0] POS_X_HI  = 4'd3;
    localparam logic [POS_W-1:0] POS_X_LO  = 4'd4;
    localparam logic [POS_W-1:0] POS_Y_HI  = 4'd5;
    localparam logic [POS_W-1:0] POS_Y_LO  = 4'd6;
    localparam logic [POS_W-1:0] POS_Z_HI  = 4'd7;
    localparam logic [POS_W-1:0] POS_Z_LO  = 4'd8;
    localparam logic [POS_W-1:0] POS_CHECK = 4'd9;
    localparam logic [POS_W-1:0] POS_TAIL  = 4'd10;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 2'd2;

    localparam logic [7:0]  RST_HEADER = 8'd123;
    localparam logic [7:0]  RST_TAIL   = 8'd125;
    localparam logic [15:0] RST_DELAY  = 16'd1000;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_TAIL = 2'd1,
        ST_XOR  = 2'd2
    } t_status;

    typedef struct packed {
        t_status            status;
        logic signed [15:0] speed_x;
        logic signed [15:0] speed_y;
        logic signed [15:0] speed_z;
    } t_frame;

endpackage

// ===== hdl/vcfr_front.sv =====
// front end: config registers, startup gate, byte position, running xor, frame classification
// depends on vcfr_pkg
`timescale 1ns / 1ps

module vcfr_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vcfr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [vcfr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_rx_byte,
    input  logic [15:0]                         i_elapsed_ticks,
    input  logic                                i_q_full,
    output logic                                o_push,
    output vcfr_pkg::t_frame                    o_frame
);

    logic [7:0]                    r_header_byte;
    logic [7:0]                    r_tail_byte;
    logic [15:0]                   r_startup_delay;
    logic [vcfr_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [7:0]                    r_xor, n_xor;
    logic                          r_xor_ok, n_xor_ok;
    logic signed [15:0]            r_sx, n_sx;
    logic signed [15:0]            r_sy, n_sy;
    logic signed [15:0]            r_sz, n_sz;
    logic                          w_take;

    assign o_ready = ~i_q_full;
    assign w_take  = i_valid & o_ready & (i_elapsed_ticks >= r_startup_delay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte   <= vcfr_pkg::RST_HEADER;
            r_tail_byte     <= vcfr_pkg::RST_TAIL;
            r_startup_delay <= vcfr_pkg::RST_DELAY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vcfr_pkg::CFG_HEADER: r_header_byte   <= i_cfg_data[7:0];
                vcfr_pkg::CFG_TAIL:   r_tail_byte     <= i_cfg_data[7:0];
                vcfr_pkg::CFG_DELAY:  r_startup_delay <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_pos    = r_pos;
        n_xor    = r_xor;
        n_xor_ok = r_xor_ok;
        n_sx     = r_sx;
        n_sy     = r_sy;
        n_sz     = r_sz;
        o_push   = 1'b0;
        if (w_take) begin
            n_xor = r_xor ^ i_rx_byte;
            unique case (r_pos)
                vcfr_pkg::POS_HEAD: begin
                    n_xor = i_rx_byte;
                    n_pos = (i_rx_byte == r_header_byte) ? r_pos + 4'd1 : r_pos;
                end
                vcfr_pkg::POS_X_HI: n_sx[15:8] = i_rx_byte;
                vcfr_pkg::POS_X_LO: n_sx[7:0]  = i_rx_byte;
                vcfr_pkg::POS_Y_HI: n_sy[15:8] = i_rx_byte;
                vcfr_pkg::POS_Y_LO: n_sy[7:0]  = i_rx_byte;
                vcfr_pkg::POS_Z_HI: n_sz[15:8] = i_rx_byte;
                vcfr_pkg::POS_Z_LO: n_sz[7:0]  = i_rx_byte;
                vcfr_pkg::POS_CHECK: begin
                    n_xor    = r_xor;
                    n_xor_ok = (r_xor == i_rx_byte);
                end
                vcfr_pkg::POS_TAIL: begin
                    n_xor  = r_xor;
                    o_push = 1'b1;
                end
                default: ;
            endcase
            if (r_pos == vcfr_pkg::POS_TAIL) begin
                n_pos = vcfr_pkg::POS_HEAD;
            end else if (r_pos != vcfr_pkg::POS_HEAD) begin
                n_pos = r_pos + 4'd1;
            end
        end
    end

    always_comb begin
        o_frame.speed_x = r_sx;
        o_frame.speed_y = r_sy;
        o_frame.speed_z = r_sz;
        if (i_rx_byte != r_tail_byte) begin
            o_frame.status = vcfr_pkg::ST_TAIL;
        end else if (!r_xor_ok) begin
            o_frame.status = vcfr_pkg::ST_XOR;
        end else begin
            o_frame.status = vcfr_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= vcfr_pkg::POS_HEAD;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xor    <= n_xor;
        r_xor_ok <= n_xor_ok;
        r_sx     <= n_sx;
        r_sy     <= n_sy;
        r_sz     <= n_sz;
    end

endmodule

// ===== hdl/vcfr_queue.sv =====
// short frame queue between front and back end
// depends on vcfr_pkg
`timescale 1ns / 1ps

module vcfr_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  vcfr_pkg::t_frame i_data,
    output logic             o_full,
    output logic             o_valid,
    output vcfr_pkg::t_frame o_data,
    input  logic             i_pop
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    vcfr_pkg::t_frame r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == FULL);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + AW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + AW'(1);
        end
        case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + CW'(1);
            2'b01:   n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== hdl/vcfr_back.sv =====
// back end: result formatting and output register
// depends on vcfr_pkg
`timescale 1ns / 1ps

module vcfr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  vcfr_pkg::t_frame   i_q_data,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_frame_status,
    output logic signed [15:0] o_speed_x,
    output logic signed [15:0] o_speed_y,
    output logic signed [15:0] o_speed_z
);

    logic               r_valid, n_valid;
    vcfr_pkg::t_status  r_status;
    logic signed [15:0] r_sx;
    logic signed [15:0] r_sy;
    logic signed [15:0] r_sz;
    logic               w_ok;

    assign o_pop = i_q_valid & (~r_valid | i_ready);
    assign w_ok  = (i_q_data.status == vcfr_pkg::ST_OK);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= i_q_data.status;
            r_sx     <= w_ok ? i_q_data.speed_x : 16'sd0;
            r_sy     <= w_ok ? i_q_data.speed_y : 16'sd0;
            r_sz     <= w_ok ? i_q_data.speed_z : 16'sd0;
        end
    end

    assign o_valid        = r_valid;
    assign o_frame_status = r_status;
    assign o_speed_x      = r_sx;
    assign o_speed_y      = r_sy;
    assign o_speed_z      = r_sz;

endmodule

// ===== hdl/velocity_command_frame_receiver_top.sv =====
// top level of the velocity command frame receiver
// depends on vcfr_pkg, vcfr_front, vcfr_queue, vcfr_back and the assertion macro header
`timescale 1ns / 1ps
`include "velocity_command_frame_receiver_top_macros.svh"

// Takes one received byte per cycle with its tick count; bytes below the startup delay are
// dropped. An 11-byte frame starting with the header byte is checked for its tail byte and
// the xor of bytes 0 to 8 against byte 9, and yields one result beat with status and three
// big-endian signed velocities (zero when rejected). Sustained rate is one byte per clock:
// position, running xor and speed bytes update in a single register stage. After its last byte,
// a result is written to the frame queue, then to the output register. Input ready drops only
// when the frame queue of QUEUE_DEPTH entries is full because the output side is stalled.
module velocity_command_frame_receiver_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [vcfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vcfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_rx_byte,
    input  logic [15:0]                     i_elapsed_ticks,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_frame_status,
    output logic signed [15:0]              o_speed_x,
    output logic signed [15:0]              o_speed_y,
    output logic signed [15:0]              o_speed_z
);

    logic             w_push;
    logic             w_full;
    vcfr_pkg::t_frame w_push_frame;
    logic             w_q_valid;
    vcfr_pkg::t_frame w_q_frame;
    logic             w_pop;

    vcfr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_rx_byte       (i_rx_byte),
        .i_elapsed_ticks (i_elapsed_ticks),
        .i_q_full        (w_full),
        .o_push          (w_push),
        .o_frame         (w_push_frame)
    );

    vcfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_frame),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_frame),
        .i_pop   (w_pop)
    );

    vcfr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_data       (w_q_frame),
        .o_pop          (w_pop),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_frame_status (o_frame_status),
        .o_speed_x      (o_speed_x),
        .o_speed_y      (o_speed_y),
        .o_speed_z      (o_speed_z)
    );

    // rejected frames carry zero velocities
    `VCFR_ASSERT_NOW(a_reject_zero, o_out_valid && (o_frame_status != vcfr_pkg::ST_OK), (o_speed_x == 16'sd0) && (o_speed_y == 16'sd0) && (o_speed_z == 16'sd0), "rejected frame with nonzero speed")
    // a queued frame with an empty output register is presented next cycle
    `VCFR_ASSERT_NEXT(a_drain, w_q_valid && !o_out_valid, o_out_valid, "queued frame not moved to output")
    // a new result beat always comes from the queue
    `VCFR_ASSERT_NEXT(a_src, !w_q_valid, !o_out_valid || $stable(o_frame_status), "result beat without queued frame")

endmodule

// ===== bench/tb_velocity_command_frame_receiver_top.sv =====
// self-checking testbench for velocity_command_frame_receiver_top
// a small scoreboard class predicts each frame result from the accepted bytes
// depends on vcfr_pkg and the top level only
`timescale 1ns / 1ps

module tb_velocity_command_frame_receiver_top;
    import vcfr_pkg::*;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned END_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef logic [7:0] t_frame_bytes [FRAME_LEN];

    typedef enum int {
        FR_GOOD,
        FR_BAD_TAIL,
        FR_BAD_XOR
    } t_frame_kind;

    class t_frame_tracker;
        logic [7:0] header;
        logic [7:0] tail;
        logic [15:0] delay;
        logic [POS_W-1:0] fill;
        logic [7:0] bytes_seen [FRAME_LEN];
        t_frame frames_due [$];
        int unsigned errors;
        int unsigned frames_checked;
        int unsigned status_seen [3];

        function void reset_state();
            header = RST_HEADER;
            tail = RST_TAIL;
            delay = RST_DELAY;
            fill = '0;
            foreach (bytes_seen[k]) bytes_seen[k] = '0;
            frames_due.delete();
            errors = 0;
            frames_checked = 0;
            foreach (status_seen[k]) status_seen[k] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_HEADER: header = data[7:0];
                CFG_TAIL:   tail = data[7:0];
                CFG_DELAY:  delay = data;
                default: ;
            endcase
        endfunction

        // advance the frame assembly by one accepted beat
        function void note_byte(logic [7:0] b, logic [15:0] ticks);
            t_frame f;
            logic [7:0] x;
            if (ticks < delay) return;
            if (fill >= FRAME_LEN) fill = '0;
            bytes_seen[fill] = b;
            if (b == header || fill != 0) fill = fill + 1'b1;
            if (fill != FRAME_LEN) return;
            fill = '0;
            f = '0;
            if (bytes_seen[POS_TAIL] != tail) begin
                f.status = ST_TAIL;
            end else begin
                x = '0;
                for (int k = 0; k < POS_CHECK; k++) x = x ^ bytes_seen[k];
                f.status = (x == bytes_seen[POS_CHECK]) ? ST_OK : ST_XOR;
            end
            if (f.status == ST_OK) begin
                f.speed_x = {bytes_seen[POS_X_HI], bytes_seen[POS_X_LO]};
                f.speed_y = {bytes_seen[POS_Y_HI], bytes_seen[POS_Y_LO]};
                f.speed_z = {bytes_seen[POS_Z_HI], bytes_seen[POS_Z_LO]};
            end
            frames_due.push_back(f);
        endfunction

        function void check_frame(logic [1:0] st, logic signed [15:0] sx,
                                  logic signed [15:0] sy, logic signed [15:0] sz);
            t_frame want;
            if (frames_due.size() == 0) begin
                $error("result beat with no frame pending: status %0d", st);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            frames_checked++;
            status_seen[int'(want.status)]++;
            if (st !== want.status) begin
                $error("frame_status expected %0d got %0d", want.status, st);
                errors++;
            end
            if (sx !== want.speed_x) begin
                $error("speed_x expected %0d got %0d", want.speed_x, sx);
                errors++;
            end
            if (sy !== want.speed_y) begin
                $error("speed_y expected %0d got %0d", want.speed_y, sy);
                errors++;
            end
            if (sz !== want.speed_z) begin
                $error("speed_z expected %0d got %0d", want.speed_z, sz);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [7:0] i_rx_byte = '0;
    logic [15:0] i_elapsed_ticks = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [1:0] o_frame_status;
    logic signed [15:0] o_speed_x;
    logic signed [15:0] o_speed_y;
    logic signed [15:0] o_speed_z;

    t_frame_tracker tracker;
    int unsigned idle_pct = 22;
    int unsigned stall_cycles = 0;
    int unsigned bytes_sent = 0;
    int unsigned settings_used = 0;

    velocity_command_frame_receiver_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_rx_byte       (i_rx_byte),
        .i_elapsed_ticks (i_elapsed_ticks),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_frame_status  (o_frame_status),
        .o_speed_x       (o_speed_x),
        .o_speed_y       (o_speed_y),
        .o_speed_z       (o_speed_z)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            tracker.check_frame(o_frame_status, o_speed_x, o_speed_y, o_speed_z);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [15:0] pick_ticks(logic [15:0] dly);
        if (dly != 0 && $urandom_range(0, 99) < 8) return 16'($urandom_range(0, dly - 1));
        return 16'($urandom_range(dly, 16'hFFFF));
    endfunction

    function automatic logic [7:0] frame_xor(t_frame_bytes fb);
        logic [7:0] x;
        x = '0;
        for (int k = 0; k < POS_CHECK; k++) x = x ^ fb[k];
        return x;
    endfunction

    function automatic t_frame_bytes build_frame(t_frame_kind kind, logic [7:0] hdr,
                                                 logic [7:0] tl);
        t_frame_bytes fb;
        fb[POS_HEAD] = hdr;
        for (int k = 1; k < POS_CHECK; k++) begin
            fb[k] = ($urandom_range(0, 99) < 12) ? hdr : 8'($urandom);
        end
        fb[POS_CHECK] = frame_xor(fb);
        if (kind == FR_BAD_XOR || (kind == FR_BAD_TAIL && $urandom_range(0, 1) == 1)) begin
            fb[POS_CHECK] = fb[POS_CHECK] ^ 8'($urandom_range(1, 255));
        end
        fb[POS_TAIL] = (kind == FR_BAD_TAIL) ? tl ^ 8'($urandom_range(1, 255)) : tl;
        return fb;
    endfunction

    // one beat; valid stays high on return until the next beat or a drain
    task automatic send_byte(input logic [7:0] b, input logic [15:0] ticks);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_rx_byte = b;
        i_elapsed_ticks = ticks;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_byte(b, ticks);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input t_frame_bytes fb, input int count);
        for (int k = 0; k < count; k++) send_byte(fb[k], pick_ticks(tracker.delay));
    endtask

    task automatic wait_drained(input int settle);
        i_in_valid = 1'b0;
        while (tracker.frames_due.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        tracker.write_reg(idx, data);
    endtask

    task automatic configure(input logic [7:0] hdr, input logic [7:0] tl,
                             input logic [15:0] dly);
        set_reg(CFG_HEADER, {8'($urandom), hdr});
        set_reg(CFG_TAIL, {8'($urandom), tl});
        set_reg(CFG_DELAY, dly);
        settings_used++;
    endtask

    task automatic run_traffic(input int unsigned budget);
        int unsigned stop_at;
        int unsigned pick;
        logic [7:0] b;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_frame(build_frame(FR_GOOD, tracker.header, tracker.tail), FRAME_LEN);
            end else if (pick < 67) begin
                send_frame(build_frame(FR_BAD_TAIL, tracker.header, tracker.tail), FRAME_LEN);
            end else if (pick < 79) begin
                send_frame(build_frame(FR_BAD_XOR, tracker.header, tracker.tail), FRAME_LEN);
            end else if (pick < 87) begin
                // truncated frame, the following beats run on as its data
                send_frame(build_frame(FR_GOOD, tracker.header, tracker.tail),
                           $urandom_range(1, FRAME_LEN - 1));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    b = 8'($urandom);
                    if (b == tracker.header && $urandom_range(0, 99) < 85) b = ~b;
                    send_byte(b, pick_ticks(tracker.delay));
                end
            end
        end
    endtask

    initial begin
        t_frame_bytes fb;
        tracker = new;
        tracker.reset_state();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // unused register index must leave the reset settings alone
        set_reg(CFG_UNUSED, 16'hFFFF);

        // gated by the startup delay, then a stray byte while hunting
        send_byte(RST_HEADER, RST_DELAY - 16'd1);
        send_byte(8'h00, 16'd0);
        send_byte(8'hFF, RST_DELAY);

        // good frame with extreme speeds and the header value inside
        fb = '{RST_HEADER, 8'h01, RST_HEADER, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF,
               8'h00, RST_TAIL};
        fb[POS_CHECK] = frame_xor(fb);
        for (int k = 0; k < FRAME_LEN; k++) send_byte(fb[k], k[0] ? 16'hFFFF : RST_DELAY);

        // wrong tail together with a bad check byte
        fb = build_frame(FR_BAD_XOR, RST_HEADER, RST_TAIL);
        fb[POS_TAIL] = RST_TAIL - 8'd1;
        for (int k = 0; k < FRAME_LEN; k++) send_byte(fb[k], RST_DELAY);

        run_traffic(60);
        wait_drained(SETTLE_CYCLES);

        idle_pct = 0;
        configure(8'h00, 8'hFF, 16'd0);
        run_traffic(90);
        wait_drained(SETTLE_CYCLES);
        idle_pct = 22;

        configure(8'hFF, 8'h00, 16'hFFFF);
        run_traffic(90);
        wait_drained(SETTLE_CYCLES);

        repeat (3) begin
            set_reg(CFG_UNUSED, 16'($urandom));
            configure(8'($urandom), 8'($urandom), 16'($urandom));
            run_traffic(90);
            wait_drained(SETTLE_CYCLES);
        end

        wait_drained(END_CYCLES);
        $display("sent %0d beats over %0d register settings, checked %0d frames",
                 bytes_sent, settings_used + 1, tracker.frames_checked);
        $display("frame outcomes: %0d accepted, %0d bad tail, %0d bad xor",
                 tracker.status_seen[ST_OK], tracker.status_seen[ST_TAIL],
                 tracker.status_seen[ST_XOR]);
        if (tracker.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== velocity_command_frame_receiver_top.f =====
+incdir+hdl
hdl/vcfr_pkg.sv
hdl/vcfr_front.sv
hdl/vcfr_queue.sv
hdl/vcfr_back.sv
hdl/velocity_command_frame_receiver_top.sv
bench/tb_velocity_command_frame_receiver_top.sv
